// ===== src/mkpe_pkg.sv =====
// Package for the matrix keypad PIN entry block: scan phase codes, character codes,
// PIN capacity and the fixed key table. No dependencies.
package mkpe_pkg;

  localparam int unsigned PinCapacity = 7;
  localparam int unsigned CntW        = 3;
  localparam int unsigned CharW       = 7;
  localparam int unsigned TickW       = 16;

  localparam logic [1:0] PhSettle   = 2'd0;
  localparam logic [1:0] PhScan     = 2'd1;
  localparam logic [1:0] PhDebounce = 2'd2;
  localparam logic [1:0] PhHold     = 2'd3;

  localparam logic [1:0] CfgSettle   = 2'd0;
  localparam logic [1:0] CfgDebounce = 2'd1;
  localparam logic [1:0] CfgRelease  = 2'd2;

  localparam logic [CharW-1:0] CharHash = 7'h23;
  localparam logic [CharW-1:0] CharStar = 7'h2A;

  typedef logic [CharW-1:0] pin_char_t;

  // Rows are "123A", "456B", "789C" and "*0#D".
  function automatic pin_char_t key_char(input logic [1:0] row, input logic [1:0] col);
    pin_char_t k;
    case ({row, col})
      4'h0:    k = 7'h31;
      4'h1:    k = 7'h32;
      4'h2:    k = 7'h33;
      4'h3:    k = 7'h41;
      4'h4:    k = 7'h34;
      4'h5:    k = 7'h35;
      4'h6:    k = 7'h36;
      4'h7:    k = 7'h42;
      4'h8:    k = 7'h37;
      4'h9:    k = 7'h38;
      4'hA:    k = 7'h39;
      4'hB:    k = 7'h43;
      4'hC:    k = CharStar;
      4'hD:    k = 7'h30;
      4'hE:    k = CharHash;
      default: k = 7'h44;
    endcase
    return k;
  endfunction

endpackage

// ===== src/matrix_keypad_pin_entry_top.sv =====
// Top level of the matrix keypad PIN entry block: scan sequencer, PIN store and
// output register. Depends on mkpe_pkg.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+--------------------------------------
//  in       | input     | in_valid_i / in_ready_o    | row_levels_i
//  out      | output    | out_valid_o / out_ready_i  | column_drive_o, key_event_o,
//           |           |                            | key_char_o, pin_done_o, pin_length_o,
//           |           |                            | pin_chars_o
//  cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each tick item is processed by the combinational next-state logic and its result is
// captured in the output register, so one item is accepted per cycle while the
// output register is empty or being drained. The output register stalls the input
// when a result is not taken. Reset leaves the scanner settling on column zero with
// an empty PIN and the configuration registers at 1, 20 and 10 ticks.
module matrix_keypad_pin_entry_top
  import mkpe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [3:0]           row_levels_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           column_drive_o,
  output logic                 key_event_o,
  output logic [CharW-1:0]     key_char_o,
  output logic                 pin_done_o,
  output logic [CntW-1:0]      pin_length_o,
  output logic [8*PinCapacity-1:0] pin_chars_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [TickW-1:0]     cfg_data_i
);

  logic [TickW-1:0] settle_q, debounce_q, release_q;
  logic [1:0]       phase_q, phase_d;
  logic [1:0]       col_q, col_d;
  logic [1:0]       row_idx_q, row_idx_d;
  logic [1:0]       held_q, held_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  pin_char_t        store_q [PinCapacity];

  logic [TickW-1:0] tick_inc, limit;
  logic             reached, do_scan, store_we;
  logic [1:0]       scan_row;
  pin_char_t        key;
  logic             ev, done;
  logic [8*PinCapacity-1:0] chars;

  logic                     out_valid_q;
  logic [3:0]               col_drive_q;
  logic                     ev_q, done_q;
  pin_char_t                char_q;
  logic [CntW-1:0]          len_q;
  logic [8*PinCapacity-1:0] chars_q;

  logic in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= 16'd1;
      debounce_q <= 16'd20;
      release_q  <= 16'd10;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSettle:   settle_q   <= cfg_data_i;
        CfgDebounce: debounce_q <= cfg_data_i;
        CfgRelease:  release_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tick_inc = (tick_q == {TickW{1'b1}}) ? tick_q : tick_q + 16'd1;
  assign key      = key_char(held_q, col_q);

  always_comb begin
    case (phase_q)
      PhSettle:   limit = settle_q;
      PhDebounce: limit = debounce_q;
      default:    limit = release_q;
    endcase
  end
  assign reached = tick_inc >= limit;

  always_comb begin
    phase_d   = phase_q;
    col_d     = col_q;
    row_idx_d = row_idx_q;
    held_d    = held_q;
    tick_d    = tick_q;
    cnt_d     = cnt_q;
    do_scan   = 1'b0;
    scan_row  = row_idx_q;
    store_we  = 1'b0;
    ev        = 1'b0;
    done      = 1'b0;
    chars     = '0;

    case (phase_q)
      PhSettle: begin
        if (reached) begin
          tick_d   = '0;
          do_scan  = 1'b1;
          scan_row = 2'd0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhScan: begin
        do_scan = 1'b1;
      end
      PhDebounce: begin
        if (!reached) begin
          tick_d = tick_inc;
        end else begin
          tick_d = '0;
          if (!row_levels_i[held_q]) begin
            phase_d = PhHold;
          end else if (row_idx_q == 2'd3) begin
            col_d     = col_q + 2'd1;
            phase_d   = PhSettle;
            row_idx_d = 2'd0;
          end else begin
            phase_d   = PhScan;
            row_idx_d = row_idx_q + 2'd1;
          end
        end
      end
      default: begin
        if (!reached) begin
          tick_d = tick_inc;
        end else begin
          tick_d = '0;
          if (row_levels_i[held_q]) begin
            ev = 1'b1;
            if (key == CharHash) begin
              if (cnt_q != '0) begin
                done  = 1'b1;
                cnt_d = '0;
                for (int i = 0; i < PinCapacity; i++) begin
                  if (CntW'(i) < cnt_q) begin
                    chars[8*i +: 8] = {1'b0, store_q[i]};
                  end
                end
              end
            end else if (key == CharStar) begin
              cnt_d = '0;
            end else if (cnt_q < CntW'(PinCapacity)) begin
              store_we = 1'b1;
              cnt_d    = cnt_q + 3'd1;
            end
            col_d     = 2'd0;
            phase_d   = PhSettle;
            row_idx_d = 2'd0;
          end
        end
      end
    endcase

    if (do_scan) begin
      if (!row_levels_i[scan_row]) begin
        held_d    = scan_row;
        row_idx_d = scan_row;
        phase_d   = PhDebounce;
        tick_d    = '0;
      end else if (scan_row == 2'd3) begin
        col_d     = col_q + 2'd1;
        phase_d   = PhSettle;
        tick_d    = '0;
        row_idx_d = 2'd0;
      end else begin
        phase_d   = PhScan;
        row_idx_d = scan_row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSettle;
      col_q     <= 2'd0;
      row_idx_q <= 2'd0;
      held_q    <= 2'd0;
      tick_q    <= '0;
      cnt_q     <= '0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      col_q     <= col_d;
      row_idx_q <= row_idx_d;
      held_q    <= held_d;
      tick_q    <= tick_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && store_we) begin
      store_q[cnt_q] <= key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_drive_q <= ~(4'b0001 << col_d);
      ev_q        <= ev;
      char_q      <= ev ? key : '0;
      done_q      <= done;
      len_q       <= done ? cnt_q : '0;
      chars_q     <= chars;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_drive_o = col_drive_q;
  assign key_event_o    = ev_q;
  assign key_char_o     = char_q;
  assign pin_done_o     = done_q;
  assign pin_length_o   = len_q;
  assign pin_chars_o    = chars_q;

`ifndef SYNTHESIS
  a_done_is_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pin_done_o |-> key_event_o && key_char_o == CharHash && pin_length_o != '0)
    else $error("PIN reported without a hash key or with an empty PIN.");

  a_event_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_event_o |-> column_drive_o == 4'b1110)
    else $error("Scanning did not restart on column zero after a key item.");

  a_held_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDebounce || phase_q == PhHold |-> row_idx_q == held_q)
    else $error("Held row differs from the row being checked.");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PinCapacity))
    else $error("PIN count beyond capacity.");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the matrix keypad PIN entry block: a scoreboard class predicts
// every scan result from the accepted row samples, and tasks play key presses on a virtual keypad.
// Depends on mkpe_pkg and matrix_keypad_pin_entry_top.
`timescale 1ns / 100ps

module testbench;
  import mkpe_pkg::*;

  typedef struct packed {
    logic [3:0]               column_drive;
    logic                     key_event;
    pin_char_t                key_char;
    logic                     pin_done;
    logic [CntW-1:0]          pin_length;
    logic [8*PinCapacity-1:0] pin_chars;
  } scan_result_t;

  typedef enum int unsigned {EndHash, EndStar, EndOpen} session_end_t;

  localparam logic [8*16-1:0] KeyMap = "123A456B789C*0#D";
  localparam int unsigned StarKey       = 12;
  localparam int unsigned HashKey       = 14;
  localparam int unsigned HoldOffCycles = 64;
  localparam int unsigned StallLimit    = 1000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [3:0]               row_levels_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [3:0]               column_drive_o;
  logic                     key_event_o;
  logic [CharW-1:0]         key_char_o;
  logic                     pin_done_o;
  logic [CntW-1:0]          pin_length_o;
  logic [8*PinCapacity-1:0] pin_chars_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i;
  logic [TickW-1:0]         cfg_data_i;

  bit          idle_on      = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;

  class keypad_scoreboard;
    logic [TickW-1:0] settle_len, debounce_len, poll_len;
    logic [TickW-1:0] tick_cnt;
    logic [1:0]       column, phase, held_row, row_idx;
    pin_char_t        pin_buf [PinCapacity];
    int unsigned      pin_count, ticks, failures;
    scan_result_t     awaited_scans [$];

    function void reset();
      settle_len   = 16'd1;
      debounce_len = 16'd20;
      poll_len     = 16'd10;
      held_row     = '0;
      pin_count    = 0;
      ticks        = 0;
      failures     = 0;
      awaited_scans.delete();
      restart_column(2'd0);
    endfunction

    function void write_reg(logic [1:0] idx, logic [TickW-1:0] data);
      case (idx)
        CfgSettle:   settle_len = data;
        CfgDebounce: debounce_len = data;
        CfgRelease:  poll_len = data;
        default: ;
      endcase
    endfunction

    function void restart_column(logic [1:0] col);
      column   = col;
      phase    = PhSettle;
      tick_cnt = '0;
      row_idx  = '0;
    endfunction

    function void next_row();
      if (row_idx == 2'd3) begin
        restart_column(column + 2'd1);
      end else begin
        row_idx = row_idx + 2'd1;
      end
    endfunction

    function bit count_up(logic [TickW-1:0] limit);
      if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= limit) begin
        tick_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_tick(logic [3:0] rows);
      scan_result_t res;
      pin_char_t    k;
      bit           sample;
      res    = '0;
      sample = 1'b0;
      ticks++;
      case (phase)
        PhSettle: begin
          if (count_up(settle_len)) begin
            phase   = PhScan;
            row_idx = '0;
            sample  = 1'b1;
          end
        end
        PhScan: begin
          sample = 1'b1;
        end
        PhDebounce: begin
          if (count_up(debounce_len)) begin
            if (!rows[held_row]) begin
              phase    = PhHold;
              tick_cnt = '0;
            end else begin
              phase = PhScan;
              next_row();
            end
          end
        end
        default: begin
          if (count_up(poll_len) && rows[held_row]) begin
            k = KeyMap[8*(15 - {held_row, column}) +: CharW];
            res.key_event = 1'b1;
            res.key_char  = k;
            if (k == CharHash) begin
              if (pin_count > 0) begin
                res.pin_done   = 1'b1;
                res.pin_length = CntW'(pin_count);
                for (int i = 0; i < pin_count; i++) begin
                  res.pin_chars[8*i +: 8] = {1'b0, pin_buf[i]};
                end
                pin_count = 0;
              end
            end else if (k == CharStar) begin
              pin_count = 0;
            end else if (pin_count < PinCapacity) begin
              pin_buf[pin_count] = k;
              pin_count++;
            end
            restart_column(2'd0);
          end
        end
      endcase
      if (sample) begin
        if (!rows[row_idx]) begin
          held_row = row_idx;
          phase    = PhDebounce;
          tick_cnt = '0;
        end else begin
          next_row();
        end
      end
      res.column_drive = ~(4'b0001 << column);
      awaited_scans.push_back(res);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 40) begin
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t want;
      if (awaited_scans.size() == 0) begin
        failures++;
        $display("%0t: result with no tick pending, expected none, got %0h", $time, got);
        return;
      end
      want = awaited_scans.pop_front();
      compare("column_drive", 64'(want.column_drive), 64'(got.column_drive));
      compare("key_event", 64'(want.key_event), 64'(got.key_event));
      compare("key_char", 64'(want.key_char), 64'(got.key_char));
      compare("pin_done", 64'(want.pin_done), 64'(got.pin_done));
      compare("pin_length", 64'(want.pin_length), 64'(got.pin_length));
      compare("pin_chars", 64'(want.pin_chars), 64'(got.pin_chars));
    endfunction

    function int unsigned pending();
      return awaited_scans.size();
    endfunction
  endclass

  keypad_scoreboard scan_sb;

  matrix_keypad_pin_entry_top dut (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic [3:0] rows);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    row_levels_i <= rows;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scan_sb.note_tick(rows);
  endtask

  function automatic logic [3:0] pressed_rows(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] rows;
    rows = 4'hF;
    if (col == scan_sb.column) rows[row] = 1'b0;
    return rows;
  endfunction

  task automatic quiet_keypad();
    while (scan_sb.phase == PhDebounce || scan_sb.phase == PhHold) send_tick(4'hF);
  endtask

  // A bounced press is let go as soon as the scanner starts debouncing it.
  task automatic press_key(input int unsigned key, input bit bounce);
    logic [1:0] row, col;
    row = 2'(key / 4);
    col = 2'(key % 4);
    quiet_keypad();
    while (scan_sb.phase != (bounce ? PhDebounce : PhHold)) send_tick(pressed_rows(row, col));
    if (!bounce) repeat ($urandom_range(0, 3)) send_tick(pressed_rows(row, col));
    quiet_keypad();
    repeat ($urandom_range(0, 3)) send_tick(4'hF);
  endtask

  task automatic pin_session(input int unsigned n_chars, input session_end_t ending);
    int unsigned key;
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 9) == 0) press_key($urandom_range(0, 15), 1'b1);
      key = $urandom_range(0, 15);
      while (key == StarKey || key == HashKey) key = $urandom_range(0, 15);
      press_key(key, 1'b0);
    end
    if (ending == EndHash) begin
      press_key(HashKey, 1'b0);
    end else if (ending == EndStar) begin
      press_key(StarKey, 1'b0);
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) send_tick(4'($urandom));
    quiet_keypad();
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scan_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [TickW-1:0] settle, input logic [TickW-1:0] debounce,
                             input logic [TickW-1:0] poll);
    logic [TickW-1:0] vals [4];
    vals = '{settle, debounce, poll, TickW'($urandom)};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      scan_sb.write_reg(2'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned stall_left;
    scan_result_t got;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.column_drive = column_drive_o;
        got.key_event    = key_event_o;
        got.key_char     = key_char_o;
        got.pin_done     = pin_done_o;
        got.pin_length   = pin_length_o;
        got.pin_chars    = pin_chars_o;
        scan_sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldOffCycles - 1;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned base_ticks, next_reload, reloads;
    logic [3:0] directed_rows [14];
    directed_rows = '{4'hF, 4'h0, 4'hE, 4'hD, 4'hB, 4'h7, 4'h1, 4'h2, 4'h4, 4'h8,
                      4'h5, 4'hA, 4'hF, 4'h3};
    scan_sb = new();
    scan_sb.reset();
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    row_levels_i <= 4'hF;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CfgSettle;
    cfg_data_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_tick(directed_rows[i]);
    quiet_keypad();
    pin_session(1, EndHash);

    load_config(16'd0, 16'd0, 16'd0);
    pin_session(9, EndHash);
    pin_session(0, EndHash);
    pin_session(2, EndStar);
    pin_session(0, EndHash);
    load_config(16'd0, 16'd0, 16'd1);
    pin_session(1, EndHash);

    // Longer counts: row 3 of the column now being scanned is always still to be sampled.
    idle_on = 1'b0;
    load_config(16'd20, 16'd30, 16'd20);
    press_key(StarKey + scan_sb.column, 1'b0);
    idle_on = 1'b1;

    base_ticks  = scan_sb.ticks;
    next_reload = 0;
    reloads     = 0;
    while (scan_sb.ticks - base_ticks < 450) begin
      if (scan_sb.ticks - base_ticks >= next_reload) begin
        if (reloads % 3 == 2) begin
          load_config(TickW'($urandom_range(0, 12)), TickW'($urandom_range(0, 30)),
                      TickW'($urandom_range(1, 15)));
        end else begin
          load_config(TickW'($urandom_range(0, 3)), TickW'($urandom_range(0, 4)),
                      TickW'($urandom_range(0, 3)));
        end
        if (reloads % 2 == 1 && idle_on) hold_off_req = 1'b1;
        reloads++;
        next_reload = next_reload + 200;
      end
      if (scan_sb.ticks - base_ticks >= 300) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       noise_burst();
        1:       press_key($urandom_range(0, 15), 1'b1);
        default: pin_session($urandom_range(0, 10), session_end_t'($urandom_range(0, 2)));
      endcase
    end

    in_valid_i <= 1'b0;
    while (scan_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (scan_sb.failures == 0 && scan_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
